/* hdl/rsrb_pkg.sv */
// Package for the RTP sequence reorder buffer: queue sizing, item types,
// controller/datapath command and status structs. No dependencies.
package rsrb_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 31;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEQ_GAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TS_GAP  = 1'd1;

  localparam logic [15:0] MAX_SEQ_GAP_RST = 16'd64;
  localparam logic [30:0] MAX_TS_GAP_RST  = 31'd48000;

  typedef struct packed {
    logic [15:0] seq_num;
    logic [31:0] rtp_time;
    logic [15:0] packet_ref;
    logic [15:0] packet_len;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_ref;
    logic [15:0] out_len;
    logic [15:0] out_seq;
    logic [31:0] out_time;
    logic        is_last;
  } out_item_t;

  typedef enum logic [1:0] {
    DEC_NEW,
    DEC_HOLD,
    DEC_NEXT,
    DEC_DROP
  } dec_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic scan_start;
    logic scan_step;
    logic hold_wr;
    logic emit;
    logic emit_in;
    logic new_flow;
    logic flush;
  } cmd_t;

  typedef struct packed {
    dec_t dec;
    logic scan_last;
    logic full;
    logic min_next;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

/* hdl/rsrb_if.sv */
// Valid/ready channel interfaces for the reorder buffer input and output items.
// Depends on rsrb_pkg.
interface rsrb_in_if;
  import rsrb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsrb_out_if;
  import rsrb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/rsrb_datapath.sv */
// Reorder buffer datapath: config and last-forwarded registers, slot storage,
// scan unit (count, duplicate, free slot, minimum), pending and output item.
// Depends on rsrb_pkg.
module rsrb_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rsrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsrb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  rsrb_pkg::in_item_t               in_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output rsrb_pkg::out_item_t              out_data,
  input  rsrb_pkg::cmd_t                   cmd,
  output rsrb_pkg::stat_t                  stat
);
  import rsrb_pkg::*;

  logic [15:0] max_seq_gap;
  logic [30:0] max_ts_gap;
  logic [15:0] last_seq;
  logic [31:0] last_time;
  in_item_t    cur;

  logic [31:0] tmag;
  logic [15:0] smag;
  logic        ds_gt1;
  logic        ds_eq1;

  logic [QUEUE_DEPTH-1:0] slot_valid;
  logic [15:0] slot_seq  [QUEUE_DEPTH];
  logic [31:0] slot_time [QUEUE_DEPTH];
  logic [15:0] slot_ref  [QUEUE_DEPTH];
  logic [15:0] slot_len  [QUEUE_DEPTH];

  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic             dup;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             min_found;
  logic [IDX_W-1:0] min_idx;
  out_item_t        min_item;

  logic      pend_valid;
  out_item_t pend;
  out_item_t src;

  logic [31:0] d;
  logic [16:0] ds;
  logic [16:0] last_inc;
  logic        out_free;
  logic        hit_valid;

  assign d        = cur.rtp_time - last_time;
  assign ds       = {1'b0, cur.seq_num} - {1'b0, last_seq};
  assign last_inc = {1'b0, last_seq} + 17'd1;
  assign out_free = !out_valid || out_ready;
  assign hit_valid = slot_valid[idx];

  always_comb begin
    if (cmd.emit_in) begin
      src = '{out_ref: cur.packet_ref, out_len: cur.packet_len, out_seq: cur.seq_num,
              out_time: cur.rtp_time, is_last: 1'b0};
    end else begin
      src = min_item;
    end
  end

  always_comb begin
    stat.scan_last  = (idx == IDX_W'(QUEUE_DEPTH - 1));
    stat.full       = (cnt == CNT_W'(QUEUE_DEPTH));
    stat.min_next   = min_found && ({1'b0, min_item.out_seq} == last_inc);
    stat.pend_valid = pend_valid;
    stat.out_free   = out_free;
    if (tmag > {1'b0, max_ts_gap} || smag > max_seq_gap) begin
      stat.dec = DEC_NEW;
    end else if (ds_gt1) begin
      stat.dec = DEC_HOLD;
    end else if (ds_eq1) begin
      stat.dec = DEC_NEXT;
    end else begin
      stat.dec = DEC_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_seq_gap <= MAX_SEQ_GAP_RST;
      max_ts_gap  <= MAX_TS_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_SEQ_GAP: max_seq_gap <= cfg_data[15:0];
        REG_MAX_TS_GAP:  max_ts_gap  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= in_data;
    end
    if (cmd.diff) begin
      tmag   <= d[31] ? (~d + 32'd1) : d;
      smag   <= ds[16] ? 16'(~ds + 17'd1) : ds[15:0];
      ds_gt1 <= !ds[16] && (ds > 17'd1);
      ds_eq1 <= (ds == 17'd1);
    end
    if (cmd.scan_start) begin
      idx        <= '0;
      cnt        <= '0;
      dup        <= 1'b0;
      free_found <= 1'b0;
      min_found  <= 1'b0;
    end else if (cmd.scan_step) begin
      idx <= idx + IDX_W'(1);
      cnt <= cnt + CNT_W'(hit_valid);
      if (hit_valid && slot_seq[idx] == cur.seq_num) begin
        dup <= 1'b1;
      end
      if (!hit_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if (hit_valid && (!min_found || slot_seq[idx] < min_item.out_seq)) begin
        min_found <= 1'b1;
        min_idx   <= idx;
        min_item  <= '{out_ref: slot_ref[idx], out_len: slot_len[idx],
                       out_seq: slot_seq[idx], out_time: slot_time[idx], is_last: 1'b0};
      end
    end
    if (cmd.hold_wr && !dup && free_found) begin
      slot_seq[free_idx]  <= cur.seq_num;
      slot_time[free_idx] <= cur.rtp_time;
      slot_ref[free_idx]  <= cur.packet_ref;
      slot_len[free_idx]  <= cur.packet_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      last_seq   <= '0;
      last_time  <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.hold_wr && !dup && free_found) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (cmd.emit) begin
        last_seq   <= src.out_seq;
        last_time  <= src.out_time;
        pend       <= src;
        pend_valid <= 1'b1;
        if (cmd.new_flow) begin
          slot_valid <= '0;
        end else if (!cmd.emit_in) begin
          slot_valid[min_idx] <= 1'b0;
        end
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if ((cmd.emit || cmd.flush) && pend_valid) begin
        out_valid <= 1'b1;
        out_data  <= '{out_ref: pend.out_ref, out_len: pend.out_len, out_seq: pend.out_seq,
                       out_time: pend.out_time, is_last: cmd.flush};
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.flush) && pend_valid |-> out_free)
    else $error("pending item pushed into a busy output register");
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.flush && !cmd.emit |=> !pend_valid)
    else $error("pending item survived a flush");
  a_new_flow_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.new_flow |=> slot_valid == '0)
    else $error("held entries survived a new flow");
`endif

endmodule

/* hdl/rsrb_ctrl.sv */
// Reorder buffer controller: sequences decide, hold, queue scan, release and
// flush of one item at a time. Depends on rsrb_pkg.
module rsrb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rsrb_pkg::stat_t stat,
  output rsrb_pkg::cmd_t  cmd
);
  import rsrb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_DECIDE,
    S_HSCAN,
    S_HWRITE,
    S_EMIT_IN,
    S_CSCAN,
    S_CDECIDE,
    S_REL,
    S_FLUSH
  } state_t;

  state_t state;
  logic   is_new;
  logic   first_pass;
  logic   can_emit;

  assign can_emit = !stat.pend_valid || stat.out_free;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = in_valid && in_ready;
    cmd.diff       = (state == S_DIFF);
    cmd.scan_step  = (state == S_HSCAN) || (state == S_CSCAN);
    cmd.hold_wr    = (state == S_HWRITE);
    cmd.scan_start = (state == S_HWRITE) || (state == S_DECIDE) ||
                     (((state == S_EMIT_IN) || (state == S_REL)) && can_emit);
    cmd.emit       = ((state == S_EMIT_IN) || (state == S_REL)) && can_emit;
    cmd.emit_in    = (state == S_EMIT_IN);
    cmd.new_flow   = (state == S_EMIT_IN) && is_new;
    cmd.flush      = (state == S_FLUSH) && stat.pend_valid && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      is_new     <= 1'b0;
      first_pass <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: state <= S_DECIDE;
        S_DECIDE: begin
          is_new <= (stat.dec == DEC_NEW);
          unique case (stat.dec)
            DEC_NEW, DEC_NEXT: state <= S_EMIT_IN;
            DEC_HOLD:          state <= S_HSCAN;
            DEC_DROP:          state <= S_FLUSH;
          endcase
        end
        S_HSCAN: begin
          if (stat.scan_last) begin
            state <= S_HWRITE;
          end
        end
        S_HWRITE: begin
          first_pass <= 1'b1;
          state      <= S_CSCAN;
        end
        S_EMIT_IN: begin
          if (can_emit) begin
            first_pass <= 1'b1;
            state      <= is_new ? S_FLUSH : S_CSCAN;
          end
        end
        S_CSCAN: begin
          if (stat.scan_last) begin
            state <= S_CDECIDE;
          end
        end
        S_CDECIDE: begin
          first_pass <= 1'b0;
          if ((first_pass && stat.full) || stat.min_next) begin
            state <= S_REL;
          end else begin
            state <= S_FLUSH;
          end
        end
        S_REL: begin
          if (can_emit) begin
            state <= S_CSCAN;
          end
        end
        S_FLUSH: begin
          if (!stat.pend_valid || stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/rtp_sequence_reorder_buffer.sv */
// Top level of the RTP sequence reorder buffer: controller plus datapath.
// Depends on rsrb_pkg, rsrb_if, rsrb_ctrl, rsrb_datapath.
//
//   port      dir   item / use
//   pkt_in    sink  seq_num, rtp_time, packet_ref, packet_len
//   pkt_out   src   out_ref, out_len, out_seq, out_time, is_last
//   cfg_*     in    0 max_seq_gap, 1 max_ts_gap
//
// One item at a time. A drop or a new flow needs no queue scan. Each queue scan
// walks QUEUE_DEPTH slots one per cycle; a next item takes (releases + 1) scans,
// and a held item one more for its own scan.
// Sync reset empties the queue at once. Output stalls hold the release loop.
module rtp_sequence_reorder_buffer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rsrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsrb_pkg::CFG_DATA_W-1:0]  cfg_data,
  rsrb_in_if.sink                          pkt_in,
  rsrb_out_if.source                       pkt_out
);
  import rsrb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rsrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pkt_in.valid),
    .in_ready (pkt_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rsrb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (pkt_in.data),
    .out_ready (pkt_out.ready),
    .out_valid (pkt_out.valid),
    .out_data  (pkt_out.data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* tb/rtp_sequence_reorder_buffer_tb.sv */
// Testbench for rtp_sequence_reorder_buffer: directed and random packet items,
// checked by a scoreboard class that predicts the reorder decisions.
// Depends on rsrb_pkg, rsrb_if and the reorder buffer RTL.
`timescale 1ns / 1ps

module rtp_sequence_reorder_buffer_tb;
  import rsrb_pkg::*;

  localparam int LIMIT = 1500000;
  localparam int DRAIN = 3 * QUEUE_DEPTH + 20;

  class reorder_scoreboard;
    logic [15:0] seq_gap;
    logic [30:0] ts_gap;
    logic [15:0] last_seq;
    logic [31:0] last_time;
    bit          held[QUEUE_DEPTH];
    in_item_t    slot[QUEUE_DEPTH];
    out_item_t   pending[$];
    int          errors;
    int          n_in;
    int          n_out;

    function new();
      seq_gap = MAX_SEQ_GAP_RST;
      ts_gap = MAX_TS_GAP_RST;
      last_seq = '0;
      last_time = '0;
      foreach (held[i]) held[i] = 0;
    endfunction

    function void forward(in_item_t it);
      out_item_t o;
      o.out_ref = it.packet_ref;
      o.out_len = it.packet_len;
      o.out_seq = it.seq_num;
      o.out_time = it.rtp_time;
      o.is_last = 1'b0;
      pending.push_back(o);
      last_seq = it.seq_num;
      last_time = it.rtp_time;
    endfunction

    function int min_slot();
      int best;
      best = -1;
      for (int i = 0; i < QUEUE_DEPTH; i++)
        if (held[i] && (best < 0 || slot[i].seq_num < slot[best].seq_num)) best = i;
      return best;
    endfunction

    function void drain_queue();
      int cnt;
      int idx;
      cnt = 0;
      foreach (held[i]) cnt += held[i];
      if (cnt >= QUEUE_DEPTH) begin
        idx = min_slot();
        held[idx] = 0;
        forward(slot[idx]);
      end
      forever begin
        idx = min_slot();
        if (idx < 0 || 32'(slot[idx].seq_num) != 32'(last_seq) + 1) break;
        held[idx] = 0;
        forward(slot[idx]);
      end
    endfunction

    function void hold_item(in_item_t it);
      foreach (held[i]) if (held[i] && slot[i].seq_num == it.seq_num) return;
      foreach (held[i])
        if (!held[i]) begin
          held[i] = 1;
          slot[i] = it;
          return;
        end
    endfunction

    function void note_input(in_item_t it);
      logic [31:0] dt;
      logic [31:0] tmag;
      int ds;
      int smag;
      int before_n;
      before_n = pending.size();
      n_in++;
      dt = it.rtp_time - last_time;
      tmag = dt[31] ? -dt : dt;
      ds = int'(it.seq_num) - int'(last_seq);
      smag = ds < 0 ? -ds : ds;
      if (tmag > {1'b0, ts_gap} || smag > int'(seq_gap)) begin
        forward(it);
        foreach (held[i]) held[i] = 0;
      end else if (ds > 1) begin
        hold_item(it);
        drain_queue();
      end else if (ds == 1) begin
        forward(it);
        drain_queue();
      end
      if (pending.size() > before_n) pending[pending.size()-1].is_last = 1'b1;
    endfunction

    task flag(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t e;
      n_out++;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected item seq %0d", got.out_seq));
        return;
      end
      e = pending.pop_front();
      if (got.out_ref !== e.out_ref)
        flag($sformatf("out_ref %h exp %h", got.out_ref, e.out_ref));
      if (got.out_len !== e.out_len)
        flag($sformatf("out_len %h exp %h", got.out_len, e.out_len));
      if (got.out_seq !== e.out_seq)
        flag($sformatf("out_seq %0d exp %0d", got.out_seq, e.out_seq));
      if (got.out_time !== e.out_time)
        flag($sformatf("out_time %h exp %h", got.out_time, e.out_time));
      if (got.is_last !== e.is_last)
        flag($sformatf("is_last %b exp %b seq %0d", got.is_last, e.is_last, e.out_seq));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rsrb_in_if  pkt_in();
  rsrb_out_if pkt_out();

  rtp_sequence_reorder_buffer u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pkt_in(pkt_in.sink), .pkt_out(pkt_out.source)
  );

  reorder_scoreboard sb = new();
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cnt = 0;
  bit hold_req = 0;
  int n_cfg = 0;

  always #10 clk = ~clk;

  initial begin
    pkt_in.valid = 1'b0;
    pkt_in.data = '0;
    pkt_out.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst && pkt_in.valid && pkt_in.ready) sb.note_input(pkt_in.data);
    if (!rst && pkt_out.valid && pkt_out.ready) sb.check_result(pkt_out.data);
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = 3000;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      pkt_out.ready <= 1'b0;
    end else begin
      pkt_out.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      pkt_in.valid <= 1'b0;
      @(negedge clk);
    end
    pkt_in.valid <= 1'b1;
    pkt_in.data <= it;
    do @(posedge clk); while (!pkt_in.ready);
    @(negedge clk);
  endtask

  task automatic send_pkt(int seq, logic [31:0] tm);
    in_item_t it;
    it.seq_num = seq[15:0];
    it.rtp_time = tm;
    it.packet_ref = 16'($urandom);
    it.packet_len = 16'($urandom);
    send_item(it);
  endtask

  task automatic wait_idle();
    pkt_in.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic set_gaps(logic [15:0] sg, logic [30:0] tg);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_MAX_SEQ_GAP;
    cfg_data <= 31'(sg);
    @(negedge clk);
    cfg_index <= REG_MAX_TS_GAP;
    cfg_data <= tg;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.seq_gap = sg;
    sb.ts_gap = tg;
    n_cfg++;
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    int r;
    int s;
    r = $urandom_range(99);
    it.packet_ref = 16'($urandom);
    it.packet_len = 16'($urandom);
    it.rtp_time = sb.last_time + $urandom_range(0, 3000);
    if (r < 8) begin
      s = $urandom_range(65535);
      it.rtp_time = $urandom;
    end else if (r < 18) begin
      s = int'(sb.last_seq) - $urandom_range(0, 5);
      it.rtp_time = sb.last_time - $urandom_range(0, 500);
    end else begin
      s = int'(sb.last_seq) + $urandom_range(1, 20);
      if (r < 22) it.rtp_time = sb.last_time + $urandom_range(40000, 60000);
    end
    if (s < 0 || s > 65535) s = $urandom_range(65535);
    it.seq_num = s[15:0];
    return it;
  endfunction

  task automatic run_random(int n, int ip, int sp);
    idle_pct = ip;
    stall_pct = sp;
    repeat (n) send_item(rand_item());
  endtask

  initial begin
    in_item_t it;
    int base;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_gaps(MAX_SEQ_GAP_RST, MAX_TS_GAP_RST);

    // next, duplicate, old, held duplicate, drain
    send_pkt(1, 0);
    send_pkt(1, 0);
    send_pkt(0, 0);
    send_pkt(3, 5);
    send_pkt(3, 6);
    send_pkt(2, 4);
    it = '{seq_num: 16'hFFFF, rtp_time: 32'hFFFF_FFFF, packet_ref: 16'hFFFF,
           packet_len: 16'hFFFF};
    send_item(it);
    it = '{seq_num: 16'h0000, rtp_time: 32'h0, packet_ref: 16'h0, packet_len: 16'h0};
    send_item(it);
    send_pkt(1, 32'h8000_0000);
    // fill the queue: the last hold releases the smallest, then all drain
    base = sb.last_seq;
    for (int k = 2; k <= QUEUE_DEPTH + 1; k++) send_pkt(base + k, sb.last_time);
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    hold_req = 1;
    run_random(55, 0, 0);
    run_random(20, 75, 0);
    wait_idle();
    set_gaps(16'hFFFF, 31'h7FFF_FFFF);
    run_random(50, 0, 75);
    set_gaps(16'd0, 31'd0);
    run_random(40, 11, 11);
    set_gaps(16'd20, 31'd1000);
    run_random(55, 75, 75);
    wait_idle();

    if (sb.pending.size() != 0) sb.flag("expected items left over");
    $display("Covered %0d input items, %0d output items, %0d register settings.",
             sb.n_in, sb.n_out, n_cfg);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
